/* rtl/bpfa_pkg.sv */
// Package: shared types, codes and constants of the bitmap page frame allocator.
`timescale 1ns / 1ps
package bpfa_pkg;

    localparam int MAX_PAGES_DEF = 4096;

    localparam int PAGE_W    = 12;
    localparam int COUNT_W   = 13;
    localparam int SPAN_W    = 13;
    localparam int WORD_BITS = 8;
    localparam int BIT_W     = 3;
    localparam int WIDX_W    = SPAN_W - BIT_W;

    localparam logic [WORD_BITS-1:0] FILL_WORD = 8'hFF;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RUN     = 2'd1;
    localparam logic [1:0] MODE_FREE    = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_ALREADY = 2'd3;

    typedef enum logic [2:0] {
        OP_SCAN,
        OP_RUN,
        OP_SET,
        OP_CLR,
        OP_FREE
    } op_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [PAGE_W-1:0]  page_index;
        logic [COUNT_W-1:0] count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [PAGE_W-1:0]  granted_page;
        logic [COUNT_W-1:0] used_count;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic fill_wr;
        logic proc;
        logic adv;
        logic next_pass;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic bad;
        logic empty;
        logic last;
        logic hit;
        logic more;
        logic out_busy;
    } stat_t;

endpackage

/* rtl/bitmap_page_frame_allocator.sv */
// Top level: bitmap page frame allocator with APB-style configuration port.
// Each transfer runs a check state, then read, process and decide states per 8-page word
// scanned, then a finish state that posts the result; no new transfer is accepted before that.
// A wrapped single-page scan and the marking pass of a run allocation each add a second pass
// with its own check and per-word states; scan length sets the number of words.
// Reset: a fill sweep marks every page used; count MAX_PAGES, hint 0.
`timescale 1ns / 1ps
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);

    logic [SPAN_W-1:0] page_limit_reg;
    cmd_t              cmd;
    stat_t             stat;

    // Configuration register: only the page limit, decoded at every offset with paddr[2] low
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - SPAN_W){1'b0}}, page_limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_limit_reg <= SPAN_W'(MAX_PAGES);
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            page_limit_reg <= pwdata[SPAN_W-1:0];
        end
    end

    // Sequence each transfer through word passes
    bpfa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the bitmap, counters and the result register
    bpfa_dp #(
        .MAX_PAGES(MAX_PAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .page_limit (page_limit_reg),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

/* rtl/bpfa_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/bpfa_ctrl.sv */
// Controller state machine: sequences fill, word passes and result delivery.
`timescale 1ns / 1ps
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_FILL = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_PROC = 7'b0010000,
        S_DEC  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.bad)
                begin
                    state_next = S_FIN;
                end
                else if (stat.empty)
                begin
                    if (stat.more)
                    begin
                        cmd.next_pass = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_PROC;
            end
            S_PROC:
            begin
                cmd.proc   = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.hit || stat.last)
                begin
                    if (stat.more)
                    begin
                        cmd.next_pass = 1'b1;
                        state_next    = S_CHK;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

endmodule

/* rtl/bpfa_dp.sv */
// Datapath: bitmap RAM, word processing, counters and result register.
`timescale 1ns / 1ps
module bpfa_dp
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [SPAN_W-1:0] page_limit,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item
);

    localparam int DEPTH = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SPAN_W-1:0] CAP =
        (MAX_PAGES > 8191) ? {SPAN_W{1'b1}} : SPAN_W'(MAX_PAGES);
    localparam logic [SPAN_W-1:0] USED_RST = SPAN_W'(MAX_PAGES);

    in_item_t          item_reg;
    op_t               op_reg, op_next;
    logic              first_reg;
    logic [SPAN_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [WIDX_W-1:0] wc_reg;
    logic [SPAN_W-1:0] run_reg, run_next;
    logic              hit_reg, hit_next, ok_reg, af_reg, af_next, bad_reg, bad_next;
    logic [SPAN_W-1:0] g_reg, g_next, end_reg, end_next;
    logic [SPAN_W-1:0] used_reg, used_next, hint_reg, hint_next;
    logic [AW-1:0]     fill_cnt_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [SPAN_W-1:0]    lim, base, pg, hi_m1;
    logic [SPAN_W:0]      sum_end;
    logic [WORD_BITS-1:0] rdata, wdata, mask, sel;
    logic                 we, found;
    logic [AW-1:0]        addr;
    logic [BIT_W:0]       pop;
    logic [1:0]           st;

    assign lim = (page_limit < CAP) ? page_limit : CAP;

    // Drive the RAM from the fill sweep or the current word
    assign addr = cmd.fill_wr ? fill_cnt_reg : AW'(wc_reg);

    bpfa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_map (
        .clk  (clk),
        .we   (we),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    assign hi_m1 = hi_reg - 1'b1;

    assign stat.fill_last = (fill_cnt_reg == AW'(DEPTH - 1));
    assign stat.bad       = bad_reg;
    assign stat.empty     = (lo_reg >= hi_reg);
    assign stat.last      = (wc_reg == hi_m1[SPAN_W-1:BIT_W]);
    assign stat.hit       = hit_reg;
    assign stat.more      = first_reg &&
        (((item_reg.mode == MODE_ALLOC) && !ok_reg) ||
         ((item_reg.mode == MODE_RUN) && ok_reg));
    assign stat.out_busy  = out_valid_reg && !out_ready;

    // End of a released range, one bit wider so it cannot wrap
    assign sum_end = {1'b0, SPAN_W'(in_item.page_index)} + {1'b0, in_item.count};

    // Pass setup on accept and on the second pass
    always_comb
    begin
        op_next  = op_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        bad_next = bad_reg;
        if (cmd.accept)
        begin
            bad_next = 1'b0;
            case (in_item.mode)
                MODE_ALLOC:
                begin
                    op_next = OP_SCAN;
                    lo_next = hint_reg;
                    hi_next = lim;
                end
                MODE_RUN:
                begin
                    op_next  = OP_RUN;
                    lo_next  = '0;
                    hi_next  = lim;
                    bad_next = (in_item.count == '0) || (in_item.count > lim);
                end
                MODE_FREE:
                begin
                    op_next  = OP_FREE;
                    lo_next  = SPAN_W'(in_item.page_index);
                    hi_next  = SPAN_W'(in_item.page_index) + 1'b1;
                    bad_next = (SPAN_W'(in_item.page_index) >= lim);
                end
                default:
                begin
                    op_next  = OP_CLR;
                    lo_next  = SPAN_W'(in_item.page_index);
                    hi_next  = (sum_end > {1'b0, lim}) ? lim : sum_end[SPAN_W-1:0];
                    bad_next = (in_item.count == '0) ||
                        (SPAN_W'(in_item.page_index) >= lim);
                end
            endcase
        end
        else if (cmd.next_pass)
        begin
            if (item_reg.mode == MODE_ALLOC)
            begin
                op_next = OP_SCAN;
                lo_next = '0;
                hi_next = (hint_reg < lim) ? hint_reg : lim;
            end
            else
            begin
                op_next = OP_SET;
                lo_next = g_reg;
                hi_next = end_reg + 1'b1;
            end
        end
    end

    // Process one bitmap word
    always_comb
    begin
        base      = {wc_reg, {BIT_W{1'b0}}};
        mask      = '0;
        sel       = '0;
        found     = 1'b0;
        pop       = '0;
        pg        = '0;
        we        = 1'b0;
        wdata     = FILL_WORD;
        run_next  = run_reg;
        hit_next  = hit_reg;
        af_next   = af_reg;
        g_next    = g_reg;
        end_next  = end_reg;
        used_next = used_reg;
        hint_next = hint_reg;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            pg      = base + SPAN_W'(b);
            mask[b] = (pg >= lo_reg) && (pg < hi_reg);
        end
        if (cmd.fill_wr)
        begin
            we = 1'b1;
        end
        else if (cmd.proc)
        begin
            case (op_reg)
                OP_SCAN:
                begin
                    for (int b = WORD_BITS - 1; b >= 0; b--)
                    begin
                        if (mask[b] && !rdata[b])
                        begin
                            sel   = WORD_BITS'(1) << b;
                            pg    = base + SPAN_W'(b);
                            found = 1'b1;
                        end
                    end
                    if (found)
                    begin
                        we        = 1'b1;
                        wdata     = rdata | sel;
                        hit_next  = 1'b1;
                        g_next    = pg;
                        used_next = used_reg + 1'b1;
                        hint_next = pg + 1'b1;
                    end
                end
                OP_RUN:
                begin
                    for (int b = 0; b < WORD_BITS; b++)
                    begin
                        if (mask[b] && !found)
                        begin
                            run_next = rdata[b] ? '0 : run_next + 1'b1;
                            if (run_next == item_reg.count)
                            begin
                                found    = 1'b1;
                                end_next = base + SPAN_W'(b);
                            end
                        end
                    end
                    if (found)
                    begin
                        hit_next = 1'b1;
                        g_next   = end_next + 1'b1 - item_reg.count;
                    end
                end
                OP_SET:
                begin
                    we    = 1'b1;
                    wdata = rdata | mask;
                    for (int b = 0; b < WORD_BITS; b++)
                    begin
                        pop = pop + (BIT_W + 1)'(mask[b] & ~rdata[b]);
                    end
                    used_next = used_reg + SPAN_W'(pop);
                end
                OP_CLR:
                begin
                    we    = 1'b1;
                    wdata = rdata & ~mask;
                    for (int b = 0; b < WORD_BITS; b++)
                    begin
                        pop = pop + (BIT_W + 1)'(mask[b] & rdata[b]);
                    end
                    used_next = used_reg - SPAN_W'(pop);
                end
                OP_FREE:
                begin
                    if ((rdata & mask) == '0)
                    begin
                        af_next = 1'b1;
                    end
                    else
                    begin
                        we        = 1'b1;
                        wdata     = rdata & ~mask;
                        used_next = used_reg - 1'b1;
                        if (lo_reg < hint_reg)
                        begin
                            hint_next = lo_reg;
                        end
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    // Result status
    always_comb
    begin
        if (bad_reg)
        begin
            st = ST_BAD;
        end
        else
        begin
            case (item_reg.mode)
                MODE_ALLOC, MODE_RUN: st = ok_reg ? ST_DONE : ST_NONE;
                MODE_FREE:            st = af_reg ? ST_ALREADY : ST_DONE;
                default:              st = ST_DONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            used_reg      <= USED_RST;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            af_reg        <= 1'b0;
            bad_reg       <= 1'b0;
            op_reg        <= OP_SCAN;
            lo_reg        <= '0;
            hi_reg        <= '0;
            wc_reg        <= '0;
            run_reg       <= '0;
        end
        else
        begin
            if (cmd.fill_wr)
            begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
            used_reg <= used_next;
            hint_reg <= hint_next;
            op_reg   <= op_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            bad_reg  <= bad_next;
            if (cmd.accept)
            begin
                first_reg <= 1'b1;
                hit_reg   <= 1'b0;
                ok_reg    <= 1'b0;
                af_reg    <= 1'b0;
                run_reg   <= '0;
                wc_reg    <= lo_next[SPAN_W-1:BIT_W];
            end
            else if (cmd.next_pass)
            begin
                first_reg <= 1'b0;
                hit_reg   <= 1'b0;
                wc_reg    <= lo_next[SPAN_W-1:BIT_W];
            end
            else if (cmd.proc)
            begin
                hit_reg <= hit_next;
                ok_reg  <= ok_reg | hit_next;
                af_reg  <= af_next;
                run_reg <= run_next;
            end
            else if (cmd.adv)
            begin
                wc_reg <= wc_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_item;
        end
        if (cmd.proc)
        begin
            g_reg   <= g_next;
            end_reg <= end_next;
        end
        if (cmd.finish)
        begin
            out_reg.status       <= st;
            out_reg.granted_page <= (st == ST_DONE &&
                (item_reg.mode == MODE_ALLOC || item_reg.mode == MODE_RUN))
                ? g_reg[PAGE_W-1:0] : '0;
            out_reg.used_count   <= used_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* bench/bpfa_scoreboard.sv */
// Checker: predicts the allocator's results from observed transfers and compares them.
`timescale 1ns / 1ps
module bpfa_scoreboard
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_item,
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0] ADDR_PAGE_LIMIT = 3'd0;

    logic [MAX_PAGES-1:0] page_used;
    int unsigned          pages_in_use;
    int unsigned          fit_hint;
    logic [COUNT_W-1:0]   managed_pages;
    out_item_t            expected_q[$];

    function automatic out_item_t apply_op(in_item_t it);
        int unsigned lim;
        int unsigned wrap_end;
        int unsigned run_len;
        int unsigned granted;
        int unsigned stop;
        logic        found;
        out_item_t   r;
        lim = (managed_pages < MAX_PAGES) ? managed_pages : MAX_PAGES;
        r.status = ST_NONE;
        granted = 0;
        found = 1'b0;
        case (it.mode)
            MODE_ALLOC:
            begin
                wrap_end = (fit_hint < lim) ? fit_hint : lim;
                for (int unsigned i = fit_hint; i < lim && !found; i++)
                    if (!page_used[i]) begin granted = i; found = 1'b1; end
                for (int unsigned i = 0; i < wrap_end && !found; i++)
                    if (!page_used[i]) begin granted = i; found = 1'b1; end
                if (found)
                begin
                    page_used[granted] = 1'b1;
                    pages_in_use++;
                    fit_hint = granted + 1;
                    r.status = ST_DONE;
                end
            end
            MODE_RUN:
            begin
                if (it.count == 0 || it.count > lim)
                    r.status = ST_BAD;
                else
                begin
                    run_len = 0;
                    for (int unsigned i = 0; i < lim && !found; i++)
                    begin
                        run_len = page_used[i] ? 0 : run_len + 1;
                        if (run_len == it.count)
                        begin
                            granted = i + 1 - it.count;
                            for (int unsigned j = granted; j <= i; j++)
                                page_used[j] = 1'b1;
                            pages_in_use += it.count;
                            r.status = ST_DONE;
                            found = 1'b1;
                        end
                    end
                end
            end
            MODE_FREE:
            begin
                if (it.page_index >= lim)
                    r.status = ST_BAD;
                else if (!page_used[it.page_index])
                    r.status = ST_ALREADY;
                else
                begin
                    page_used[it.page_index] = 1'b0;
                    pages_in_use--;
                    if (it.page_index < fit_hint)
                        fit_hint = it.page_index;
                    r.status = ST_DONE;
                end
            end
            default:
            begin
                if (it.count == 0 || it.page_index >= lim)
                    r.status = ST_BAD;
                else
                begin
                    // clip the range at the managed limit
                    stop = it.page_index + it.count;
                    if (stop > lim)
                        stop = lim;
                    for (int unsigned i = it.page_index; i < stop; i++)
                        if (page_used[i])
                        begin
                            page_used[i] = 1'b0;
                            pages_in_use--;
                        end
                    r.status = ST_DONE;
                end
            end
        endcase
        r.granted_page = granted[PAGE_W-1:0];
        r.used_count = pages_in_use[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            page_used = '1;
            pages_in_use = MAX_PAGES;
            fit_hint = 0;
            managed_pages = COUNT_W'(MAX_PAGES);
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_PAGE_LIMIT)
                managed_pages = pwdata[COUNT_W-1:0];
            if (in_valid && in_ready)
                expected_q.push_back(apply_op(in_item));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: %p", out_item);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        fail_count++;
                    end
                    if (out_item.granted_page !== want.granted_page)
                    begin
                        $error("granted_page: expected %0d, got %0d",
                               want.granted_page, out_item.granted_page);
                        fail_count++;
                    end
                    if (out_item.used_count !== want.used_count)
                    begin
                        $error("used_count: expected %0d, got %0d",
                               want.used_count, out_item.used_count);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

/* bench/bitmap_page_frame_allocator_test.sv */
// Testbench top: stimulus, idling and verdict for the bitmap page frame allocator.
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_test;
    import bpfa_pkg::*;

    localparam int          IDLE_LIMIT      = 40000;
    localparam logic [2:0]  ADDR_PAGE_LIMIT = 3'd0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;

    int fail_count;
    int pending;
    int burst_left = 0;
    int idle_cycles = 0;
    int cur_limit = MAX_PAGES_DEF;

    bitmap_page_frame_allocator dut (.*);

    bpfa_scoreboard checker_i (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
        .fail_count, .pending
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: switch between no stalls, random stalls and sparse ready
    // so back-pressure holds results in the finish state.
    int stall_style = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(2);
            stall_left <= $urandom_range(16, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(1);
            default: out_ready <= ($urandom_range(3) == 0);
        endcase
    end

    // Watchdog: count cycles in which no transfer happens on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Hold one item until transferred; then either keep valid high for the
    // next item of the burst or drop it for a random gap.
    task automatic send_item(input logic [1:0] mode, input int page, input int cnt);
        in_item_t it;
        it.mode = mode;
        it.page_index = page[PAGE_W-1:0];
        it.count = cnt[COUNT_W-1:0];
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    // Drop valid right at the last transfer, wait for every expected result,
    // then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_total(input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PAGE_LIMIT;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        cur_limit = (value < MAX_PAGES_DEF) ? value : MAX_PAGES_DEF;
    endtask

    // Random item: mostly in-range pages and short runs, with some
    // zero, oversized and full-width values mixed in.
    task automatic send_random();
        int pick;
        int page;
        int cnt;
        logic [1:0] mode;
        pick = $urandom_range(99);
        mode = (pick < 35) ? MODE_ALLOC : (pick < 55) ? MODE_RUN :
               (pick < 80) ? MODE_FREE : MODE_RELEASE;
        if (cur_limit > 0 && $urandom_range(99) < 85)
            page = $urandom_range(cur_limit - 1);
        else
            page = $urandom_range(4095);
        pick = $urandom_range(99);
        if (pick < 10)
            cnt = 0;
        else if (pick < 20)
            cnt = $urandom_range(8191);
        else if (pick < 28)
            cnt = cur_limit + $urandom_range(1);
        else
            cnt = $urandom_range(1, (mode == MODE_RELEASE) ? 24 : 8);
        send_item(mode, page, cnt);
    endtask

    int limits[8] = '{1, 37, 64, 8191, 256, 0, 4096, 13};
    int lengths[8] = '{60, 200, 200, 30, 190, 10, 40, 100};

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // advance past the fill sweep before the first transfer
        while (!in_ready) @(posedge clk);

        // Directed part at full capacity: every page starts used.
        send_item(MODE_ALLOC, 0, 0);          // nothing free
        send_item(MODE_RUN, 0, 0);            // zero-length run
        send_item(MODE_RUN, 0, 4097);         // run longer than limit
        send_item(MODE_FREE, 4095, 0);
        send_item(MODE_FREE, 4095, 0);        // double free
        send_item(MODE_RELEASE, 0, 0);        // zero-length release
        send_item(MODE_ALLOC, 4095, 8191);    // first pass grants top page
        send_item(MODE_RELEASE, 4095, 8191);  // clipped at limit
        send_item(MODE_RELEASE, 0, 4096);     // everything free
        send_item(MODE_RUN, 0, 4096);         // whole map as one run
        send_item(MODE_RELEASE, 4000, 10);
        send_item(MODE_ALLOC, 0, 0);          // hint moves to 4001
        drain();

        // Lowered limit below the hint: first pass empty, wrap stops at limit.
        write_total(16);
        send_item(MODE_RELEASE, 0, 16);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_FREE, 20, 0);          // out of range
        send_item(MODE_RELEASE, 16, 1);       // release starting at limit
        drain();

        // No pages managed: every operation fails.
        write_total(0);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_RUN, 0, 1);
        send_item(MODE_FREE, 0, 0);
        send_item(MODE_RELEASE, 0, 1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_total(limits[p]);
            for (int n = 0; n < lengths[p]; n++)
                send_random();
            drain();
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/bpfa_pkg.sv
rtl/bpfa_ram.sv
rtl/bpfa_ctrl.sv
rtl/bpfa_dp.sv
rtl/bitmap_page_frame_allocator.sv
bench/bpfa_scoreboard.sv
bench/bitmap_page_frame_allocator_test.sv
